// ===== rtl/core/julian_day_to_gregorian_date_assert.svh =====
// Assertion macros for the Julian day to Gregorian date converter.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef JULIAN_DAY_TO_GREGORIAN_DATE_ASSERT_SVH
`define JULIAN_DAY_TO_GREGORIAN_DATE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define JDGD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define JDGD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/jdgd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the Julian day converter.
// No dependencies.
package jdgd_pkg;

    localparam int FRAC_BITS_DEF = 32;
    localparam int JD_BITS_DEF   = 36;

    localparam int BASE_WHOLE     = 1721060;
    localparam int DJ_MAX         = 1000000000;
    localparam int COMMON_YR_DAYS = 365;
    localparam int LONG_YR        = 366;
    localparam int ERA_YEARS      = 400;
    localparam int ERA_DAYS       = 146097;
    localparam int YEAR_MAX       = 134217727;
    localparam int YEAR_MIN       = -134217728;

    localparam int YEAR_W  = 28;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int REM_W   = 18;   // day within a 400-year cycle
    localparam int PW      = 19;   // remainder during quotient fix-up, below 3 * ERA_DAYS
    localparam int PRE_BITS = 17;  // low day bits dropped for the cycle quotient estimate
    localparam int YO_W    = 9;    // year within cycle, also year quotient width
    localparam int YO_LAST = 399;
    localparam int YSTEPS  = 4;
    localparam int MONTHS  = 12;

    // rem / 366 as (rem * YR_RECIP) >> YR_SHIFT, exact for any rem in a cycle.
    localparam int YR_SHIFT   = 27;
    localparam int YR_RECIP   = (1 << YR_SHIFT) / LONG_YR + 1;
    localparam int YR_RECIP_W = 19;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DCALC,
        ST_MAG,
        ST_QEST,
        ST_QREM,
        ST_QADJ,
        ST_FIX,
        ST_YDIV,
        ST_YINIT,
        ST_YSUB,
        ST_YSTEP,
        ST_MSTEP,
        ST_YR,
        ST_FIN
    } jdgd_state_t;

    // Leap rule for a year offset 0..399 inside a cycle.
    function automatic logic leap_in_cycle(input logic [YO_W-1:0] yo);
        logic lp;
        if (yo == YO_W'(0))
            lp = 1'b1;
        else if (yo == YO_W'(100) || yo == YO_W'(200) || yo == YO_W'(300))
            lp = 1'b0;
        else
            lp = (yo[1:0] == 2'b00);
        return lp;
    endfunction

    // mp / 100 for mp below 400.
    function automatic logic [1:0] cent_of(input logic [YO_W-1:0] mp);
        logic [1:0] c;
        c = 2'(mp >= YO_W'(100)) + 2'(mp >= YO_W'(200)) + 2'(mp >= YO_W'(300));
        return c;
    endfunction

    function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                       input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                      len = leap ? DAY_W'(29) : DAY_W'(28);
            4'd4, 4'd6, 4'd9, 4'd11:   len = DAY_W'(30);
            default:                   len = DAY_W'(31);
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/core/jdgd_alu.sv =====
`timescale 1ns / 1ps
// Shared subtract/compare unit: res = a - b, ge = (a >= b) unsigned.
// No dependencies.
module jdgd_alu #(
    parameter int AW = 38
) (
    input  logic [AW-1:0] a,
    input  logic [AW-1:0] b,
    output logic [AW-1:0] res,
    output logic          ge
);
    logic [AW:0] diff;

    assign diff = {1'b0, a} - {1'b0, b};
    assign res  = diff[AW-1:0];
    assign ge   = ~diff[AW];

endmodule

// ===== rtl/core/julian_day_to_gregorian_date.sv =====
`timescale 1ns / 1ps
// Julian date to proleptic Gregorian date; one word in, one word out.
// A rejected date goes straight to the output step; else the sequencer runs the day count,
// magnitude, cycle quotient estimate and fix-ups, floor fix, year steps and month steps.
// No new word is taken before the result is written; a held out_stall delays that.
// Reset (rst_n, async, active low) clears the sequencer and the output valid only.
// Depends on jdgd_pkg, jdgd_alu and julian_day_to_gregorian_date_assert.svh.
module julian_day_to_gregorian_date #(
    parameter int FRAC_BITS = jdgd_pkg::FRAC_BITS_DEF,
    parameter int JD_BITS   = jdgd_pkg::JD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [JD_BITS-1:0]           jd_whole,
    input  logic [FRAC_BITS-1:0]         jd_frac,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         status,
    output logic [jdgd_pkg::YEAR_W-1:0]  year,
    output logic [jdgd_pkg::MONTH_W-1:0] month,
    output logic [jdgd_pkg::DAY_W-1:0]   day,
    output logic [FRAC_BITS-1:0]         day_fraction
);
    import jdgd_pkg::*;

    // Datapath widths.
    localparam int AW   = JD_BITS + 2;                   // signed day count d
    localparam int QW1  = JD_BITS - PRE_BITS;            // cycle quotient bits
    localparam int DVW  = (QW1 > YO_W) ? QW1 : YO_W;     // quotient register
    localparam int CNW  = $clog2(YSTEPS + 1);
    localparam int NW   = QW1 + 1;                       // signed cycle count
    localparam int YW   = ((JD_BITS - 6 > YEAR_W) ? JD_BITS - 6 : YEAR_W) + 1;
    localparam int CW   = ((JD_BITS > 31) ? JD_BITS : 31) + 1;
    localparam int QT   = QW1 + 1;                       // estimate shift
    localparam int QPW  = QW1 + QT;
    localparam int YPW  = REM_W + YR_RECIP_W;

    // Cycle quotient estimate: top day bits times 2^(PRE_BITS+QT)/ERA_DAYS.
    // Never above the true quotient and at most two below it.
    localparam longint CYC_RECIP_L = (longint'(1) << (PRE_BITS + QT)) / longint'(ERA_DAYS);
    localparam logic [QT-1:0] CYC_RECIP = QT'(CYC_RECIP_L);

    localparam logic signed [CW-1:0] DJ_LIM = CW'(DJ_MAX);
    localparam logic signed [YW-1:0] YR_HI  = YW'(YEAR_MAX);
    localparam logic signed [YW-1:0] YR_LO  = YW'(YEAR_MIN);
    localparam logic signed [YW-1:0] YR_CYC = YW'(ERA_YEARS);

    jdgd_state_t state_reg, state_next;

    logic [JD_BITS-1:0]    w_reg, w_next;
    logic                  carry_reg, carry_next;
    logic [FRAC_BITS-1:0]  frac_reg, frac_next;
    logic                  reject_reg, reject_next;
    logic [AW-1:0]         acc_reg, acc_next;
    logic                  neg_reg, neg_next;
    logic [PW-1:0]         p_reg, p_next;
    logic [DVW-1:0]        q_reg, q_next;
    logic [CNW-1:0]        cnt_reg, cnt_next;
    logic signed [NW-1:0]  n_reg, n_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [REM_W-1:0]      cursor_reg, cursor_next;
    logic [REM_W-1:0]      left_reg, left_next;
    logic [YO_W-1:0]       yo_reg, yo_next;
    logic [MONTH_W-1:0]    month_reg, month_next;
    logic signed [YW-1:0]  yfull_reg, yfull_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  status_reg, status_next;
    logic [YEAR_W-1:0]     year_reg, year_next;
    logic [MONTH_W-1:0]    omonth_reg, omonth_next;
    logic [DAY_W-1:0]      day_reg, day_next;
    logic [FRAC_BITS-1:0]  dfrac_reg, dfrac_next;

    // Shared unit.
    logic [AW-1:0] alu_a, alu_b, alu_res;
    logic          alu_ge;

    jdgd_alu #(
        .AW(AW)
    ) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .ge  (alu_ge)
    );

    // Scratch values.
    logic signed [CW-1:0] w_ext;
    logic                 in_reject;
    logic [AW-1:0]        mag;
    logic [REM_W-1:0]     r_fix;
    logic [QW1-1:0]       q_fix;
    logic [QPW-1:0]       qprod;
    logic [QW1-1:0]       q_est;
    logic [AW-1:0]        qmul;
    logic [YPW-1:0]       yprod;
    logic [YO_W-1:0]      qy, more, mp;
    logic [REM_W-1:0]     cur_calc;
    logic signed [YW-1:0] ysat;
    logic                 out_free;
    logic                 month_ok, date_ok, zeroed;

    assign w_ext     = CW'($signed(jd_whole));
    assign in_reject = (w_ext > DJ_LIM) || ((w_ext == DJ_LIM) && (jd_frac != '0));
    assign r_fix     = p_reg[REM_W-1:0];
    assign q_fix     = q_reg[QW1-1:0];
    assign qprod     = QPW'(acc_reg[JD_BITS-1:PRE_BITS]) * QPW'(CYC_RECIP);
    assign q_est     = qprod[QT +: QW1];
    assign qmul      = AW'(q_fix) * AW'(ERA_DAYS);
    assign yprod     = YPW'(rem_reg) * YPW'(YR_RECIP);
    assign qy        = q_reg[YO_W-1:0];
    assign more      = qy - YO_W'(1);
    assign mp        = qy - YO_W'(2);
    assign out_free  = !out_valid_reg || !out_stall;

    // Days before the first year that the stepping loop still has to test.
    assign cur_calc = REM_W'(more * COMMON_YR_DAYS) + REM_W'(mp >> 2)
                      - REM_W'(cent_of(mp)) + REM_W'(1);

    always_comb
    begin
        if (yfull_reg > YR_HI)
            ysat = YR_HI;
        else if (yfull_reg < YR_LO)
            ysat = YR_LO;
        else
            ysat = yfull_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        w_next         = w_reg;
        carry_next     = carry_reg;
        frac_next      = frac_reg;
        reject_next    = reject_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        rem_next       = rem_reg;
        cursor_next    = cursor_reg;
        left_next      = left_reg;
        yo_next        = yo_reg;
        month_next     = month_reg;
        yfull_next     = yfull_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        year_next      = year_reg;
        omonth_next    = omonth_reg;
        day_next       = day_reg;
        dfrac_next     = dfrac_reg;
        alu_a          = '0;
        alu_b          = '0;
        mag            = acc_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // Adding half a day: the top fraction bit is the carry.
                    w_next      = jd_whole;
                    carry_next  = jd_frac[FRAC_BITS-1];
                    frac_next   = {~jd_frac[FRAC_BITS-1], jd_frac[FRAC_BITS-2:0]};
                    reject_next = in_reject;
                    state_next  = in_reject ? ST_FIN : ST_DCALC;
                end
            end

            ST_DCALC:
            begin
                // d = w - base + carry
                alu_a      = AW'($signed(w_reg));
                alu_b      = carry_reg ? AW'(BASE_WHOLE - 1) : AW'(BASE_WHOLE);
                acc_next   = alu_res;
                state_next = ST_MAG;
            end

            ST_MAG:
            begin
                // Work on |d|, keep the sign for the floor fix.
                alu_a      = '0;
                alu_b      = acc_reg;
                mag        = acc_reg[AW-1] ? alu_res : acc_reg;
                neg_next   = acc_reg[AW-1];
                acc_next   = mag;
                state_next = ST_QEST;
            end

            ST_QEST:
            begin
                q_next     = DVW'(q_est);
                state_next = ST_QREM;
            end

            ST_QREM:
            begin
                // Remainder against the estimate, below three times ERA_DAYS.
                alu_a      = acc_reg;
                alu_b      = qmul;
                p_next     = alu_res[PW-1:0];
                state_next = ST_QADJ;
            end

            ST_QADJ:
            begin
                // Bring the remainder under one cycle.
                alu_a = AW'(p_reg);
                alu_b = AW'(ERA_DAYS);
                if (alu_ge)
                begin
                    p_next = alu_res[PW-1:0];
                    q_next = q_reg + DVW'(1);
                end
                else
                    state_next = ST_FIX;
            end

            ST_FIX:
            begin
                // Floor division for negative day counts.
                alu_a = AW'(ERA_DAYS);
                alu_b = AW'(r_fix);
                if (neg_reg && (r_fix != '0))
                begin
                    n_next   = ~{1'b0, q_fix};
                    rem_next = alu_res[REM_W-1:0];
                end
                else if (neg_reg)
                begin
                    n_next   = NW'(0) - {1'b0, q_fix};
                    rem_next = '0;
                end
                else
                begin
                    n_next   = {1'b0, q_fix};
                    rem_next = r_fix;
                end
                state_next = ST_YDIV;
            end

            ST_YDIV:
            begin
                // rem / 366 by reciprocal, exact over a whole cycle.
                q_next     = DVW'(yprod[YR_SHIFT +: YO_W]);
                state_next = ST_YINIT;
            end

            ST_YINIT:
            begin
                if (qy >= YO_W'(2))
                begin
                    cursor_next = cur_calc;
                    yo_next     = more;
                end
                else
                begin
                    cursor_next = '0;
                    yo_next     = '0;
                end
                state_next = ST_YSUB;
            end

            ST_YSUB:
            begin
                alu_a      = AW'(rem_reg);
                alu_b      = AW'(cursor_reg);
                left_next  = alu_res[REM_W-1:0];
                cnt_next   = '0;
                state_next = ST_YSTEP;
            end

            ST_YSTEP:
            begin
                alu_a = AW'(left_reg);
                alu_b = leap_in_cycle(yo_reg) ? AW'(LONG_YR) : AW'(COMMON_YR_DAYS);
                if ((cnt_reg == CNW'(YSTEPS)) || (yo_reg == YO_W'(YO_LAST)) || !alu_ge)
                begin
                    month_next = MONTH_W'(1);
                    state_next = ST_MSTEP;
                end
                else
                begin
                    left_next = alu_res[REM_W-1:0];
                    yo_next   = yo_reg + YO_W'(1);
                    cnt_next  = cnt_reg + CNW'(1);
                end
            end

            ST_MSTEP:
            begin
                alu_a = AW'(left_reg);
                alu_b = AW'(days_in_month(month_reg, leap_in_cycle(yo_reg)));
                if ((month_reg == MONTH_W'(MONTHS)) || !alu_ge)
                    state_next = ST_YR;
                else
                begin
                    left_next  = alu_res[REM_W-1:0];
                    month_next = month_reg + MONTH_W'(1);
                end
            end

            ST_YR:
            begin
                yfull_next = YW'(n_reg) * YR_CYC + $signed(YW'({1'b0, yo_reg}));
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = reject_reg;
                    if (reject_reg)
                    begin
                        year_next   = '0;
                        omonth_next = '0;
                        day_next    = '0;
                        dfrac_next  = '0;
                    end
                    else
                    begin
                        year_next   = ysat[YEAR_W-1:0];
                        omonth_next = month_reg;
                        day_next    = DAY_W'(left_reg + REM_W'(1));
                        dfrac_next  = frac_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg      <= w_next;
        carry_reg  <= carry_next;
        frac_reg   <= frac_next;
        reject_reg <= reject_next;
        acc_reg    <= acc_next;
        neg_reg    <= neg_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        cnt_reg    <= cnt_next;
        n_reg      <= n_next;
        rem_reg    <= rem_next;
        cursor_reg <= cursor_next;
        left_reg   <= left_next;
        yo_reg     <= yo_next;
        month_reg  <= month_next;
        yfull_reg  <= yfull_next;
        status_reg <= status_next;
        year_reg   <= year_next;
        omonth_reg <= omonth_next;
        day_reg    <= day_next;
        dfrac_reg  <= dfrac_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign year         = year_reg;
    assign month        = omonth_reg;
    assign day          = day_reg;
    assign day_fraction = dfrac_reg;

    assign month_ok = (month_reg >= MONTH_W'(1)) && (month_reg <= MONTH_W'(MONTHS));
    assign date_ok  = (day != '0) && (month != '0) && (month <= MONTH_W'(MONTHS));
    assign zeroed   = (year == '0) && (month == '0) && (day == '0);

`include "julian_day_to_gregorian_date_assert.svh"

    `JDGD_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")
    `JDGD_ASSERT_NOW(a_month_range, state_reg == ST_MSTEP, month_ok, "month counter out of range")
    `JDGD_ASSERT_NOW(a_ystep_bound, state_reg == ST_YSTEP, cnt_reg <= CNW'(YSTEPS), "year steps")
    `JDGD_ASSERT_NOW(a_ok_fields, out_valid && !status, date_ok, "bad date in result")
    `JDGD_ASSERT_NOW(a_reject_zero, out_valid && status, zeroed, "rejected word not zeroed")

endmodule
